// ===== rtl/mmc_pkg.sv =====
// shared types and constants for the magnetometer min/max calibrator
// no dependencies; used by the channel interfaces and the top level
package mmc_pkg;

  typedef enum logic [1:0] {
    KIND_MEASURE = 2'd0,
    KIND_START   = 2'd1,
    KIND_CAL     = 2'd2,
    KIND_FINISH  = 2'd3
  } kind_t;

  localparam int CAL_W = 32;

  typedef logic signed [CAL_W-1:0] cal_t;

  localparam cal_t CAL_MAX = 32'sh7FFF_FFFF;
  localparam cal_t CAL_MIN = 32'sh8000_0000;

  localparam logic REPORT_MEASURE = 1'b0;
  localparam logic REPORT_FINISH  = 1'b1;

  localparam int AXES = 3;

endpackage

// ===== rtl/mmc_sample_if.sv =====
// input channel of the calibrator: one three-axis sample beat with its kind
// depends on mmc_pkg
interface mmc_sample_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  mmc_pkg::kind_t                kind;
  logic signed [SAMPLE_BITS-1:0] raw_x;
  logic signed [SAMPLE_BITS-1:0] raw_y;
  logic signed [SAMPLE_BITS-1:0] raw_z;

  modport source (output valid, kind, raw_x, raw_y, raw_z, input ready);
  modport sink   (input valid, kind, raw_x, raw_y, raw_z, output ready);
endinterface

// ===== rtl/mmc_result_if.sv =====
// output channel of the calibrator: corrected sample or finish report beat
// depends on mmc_pkg
interface mmc_result_if ();
  logic          valid;
  logic          ready;
  mmc_pkg::cal_t cal_x;
  mmc_pkg::cal_t cal_y;
  mmc_pkg::cal_t cal_z;
  logic          report_kind;
  logic          scale_error;

  modport source (output valid, cal_x, cal_y, cal_z, report_kind, scale_error, input ready);
  modport sink   (input valid, cal_x, cal_y, cal_z, report_kind, scale_error, output ready);
endinterface

// ===== rtl/mmc_div.sv =====
// restoring shift-subtract divider, one quotient bit per cycle
// no dependencies; used by the calibrator top level for the scale quotient
module mmc_div #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 18
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             fits;
  logic [DEN_W-1:0] rem_next;

  assign rem_sh   = {rem, quo[NUM_W-1]};
  assign rem_sub  = rem_sh - {1'b0, den_q};
  assign fits     = rem_sh >= {1'b0, den_q};
  assign rem_next = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        quo   <= num;
        den_q <= den;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[NUM_W-2:0], fits};
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/magnetometer_min_max_calibrator.sv =====
// Three-axis magnetometer min/max calibrator. A start beat resets the per-axis
// min/max trackers, calibration beats widen them, and a finish beat sets each
// hard-iron offset to (min+max)/2 and each soft-iron scale to mean(d)/d, d being
// the truncated half-range; it returns a report with scale_error set when some d
// is zero (scales then kept). Measure beats return (raw-offset)*scale as signed
// Q23.8, rounded and saturated. One beat is worked on at a time, one axis per
// step: start is done in the idle state, a calibration beat tracks each axis, a
// measure beat multiplies and rounds each axis and waits on the output handshake,
// and a finish beat sets offsets and d, then runs the bit-serial scale divider.
// A result waiting at the output does not hold off the next sample beat.
// depends on mmc_pkg, mmc_sample_if, mmc_result_if, mmc_div
module magnetometer_min_max_calibrator #(
  parameter int SAMPLE_BITS     = 16,
  parameter int SCALE_FRAC_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  mmc_sample_if.sink   sample,
  mmc_result_if.source result
);

  localparam int S         = SAMPLE_BITS;
  localparam int F         = SCALE_FRAC_BITS;
  localparam int CAL_W     = mmc_pkg::CAL_W;
  localparam int SCALE_W   = 8 + F;
  localparam int SUMD_W    = S + 2;
  localparam int DEN_W     = S + 2;
  localparam int NUM_W     = S + F + 3;
  localparam int MAG_W     = S + 2;
  localparam int PROD_W    = MAG_W + SCALE_W;
  localparam int OUT_SHIFT = F - 7;
  localparam int R_W       = PROD_W + 1 - OUT_SHIFT;
  localparam int CMP_W     = (R_W > 33) ? R_W : 33;

  localparam logic signed [S-1:0]   TRACK_HI  = {1'b0, {(S-1){1'b1}}};
  localparam logic signed [S-1:0]   TRACK_LO  = {1'b1, {(S-1){1'b0}}};
  localparam logic [SCALE_W-1:0]    SCALE_ONE = SCALE_W'(1) << F;
  localparam logic [SCALE_W-1:0]    SCALE_MAX = {SCALE_W{1'b1}};
  localparam logic [PROD_W:0]       RND_HALF  = (PROD_W + 1)'(1) << (OUT_SHIFT - 1);
  localparam logic [CMP_W-1:0]      POS_LIM   = CMP_W'(33'h0_7FFF_FFFF);
  localparam logic [CMP_W-1:0]      NEG_LIM   = CMP_W'(33'h0_8000_0000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRACK,
    ST_SPAN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MUL,
    ST_RND,
    ST_EMIT
  } state_t;

  state_t                    state;
  logic [1:0]                axis;
  logic                      report;
  logic signed [S-1:0]       raw_q       [mmc_pkg::AXES];
  logic signed [S-1:0]       track_min   [mmc_pkg::AXES];
  logic signed [S-1:0]       track_max   [mmc_pkg::AXES];
  logic signed [S:0]         offset_sum  [mmc_pkg::AXES];
  logic [SCALE_W-1:0]        axis_scale  [mmc_pkg::AXES];
  logic signed [S-1:0]       span        [mmc_pkg::AXES];
  logic signed [SUMD_W-1:0]  span_sum;
  logic                      span_err;
  logic [PROD_W-1:0]         prod;
  logic                      prod_neg;
  mmc_pkg::cal_t             cal_acc     [mmc_pkg::AXES];

  logic                      out_valid;
  mmc_pkg::cal_t             out_cal     [mmc_pkg::AXES];
  logic                      out_report;
  logic                      out_error;

  logic signed [S-1:0]       cur_raw;
  logic signed [S-1:0]       cur_min;
  logic signed [S-1:0]       cur_max;
  logic signed [S:0]         cur_off;
  logic signed [S-1:0]       cur_span;
  logic signed [S:0]         mm_diff;
  logic signed [S:0]         mm_adj;
  logic signed [S-1:0]       span_new;
  logic signed [S:0]         off_new;
  logic [S-1:0]              span_mag;
  logic [SUMD_W-1:0]         sum_mag;
  logic [S+1:0]              span3;
  logic [NUM_W-1:0]          div_num;
  logic [DEN_W-1:0]          div_den;
  logic                      div_start;
  logic                      div_done;
  logic [NUM_W-1:0]          div_quo;
  logic                      scale_zero;
  logic [SCALE_W-1:0]        scale_new;
  logic signed [S+1:0]       diff2;
  logic [MAG_W-1:0]          diff_mag;
  logic [PROD_W-1:0]         mul_out;
  logic [PROD_W:0]           rnd_sum;
  logic [R_W-1:0]            rnd_val;
  logic [CMP_W-1:0]          r_ext;
  mmc_pkg::cal_t             cal_new;
  logic                      out_free;

  assign cur_raw  = raw_q[axis];
  assign cur_min  = track_min[axis];
  assign cur_max  = track_max[axis];
  assign cur_off  = offset_sum[axis];
  assign cur_span = span[axis];

  // half-range truncated toward zero, and the offset in half-lsb units
  assign mm_diff  = {cur_max[S-1], cur_max} - {cur_min[S-1], cur_min};
  assign mm_adj   = mm_diff + (S + 1)'(mm_diff[S]);
  assign span_new = mm_adj[S:1];
  assign off_new  = {cur_min[S-1], cur_min} + {cur_max[S-1], cur_max};

  // scale = round(sum * 2^F / (3 d)) as (2 num + den) / (2 den)
  assign span_mag = cur_span[S-1] ? -cur_span : cur_span;
  assign sum_mag  = span_sum[SUMD_W-1] ? -span_sum : span_sum;
  assign span3    = ({2'b00, span_mag} << 1) + {2'b00, span_mag};
  assign div_num  = (NUM_W'(sum_mag) << (F + 1)) + NUM_W'(span3);
  assign div_den  = DEN_W'({span3, 1'b0});
  assign div_start = (state == ST_DIV_START);

  mmc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign scale_zero = (span_sum == '0) || (span_sum[SUMD_W-1] != cur_span[S-1]);
  assign scale_new  = scale_zero ? '0 :
                      (|div_quo[NUM_W-1:SCALE_W]) ? SCALE_MAX : div_quo[SCALE_W-1:0];

  // correction: (2 raw - offset_sum) * scale, one axis per pass
  assign diff2    = {cur_raw[S-1], cur_raw, 1'b0} - {cur_off[S], cur_off};
  assign diff_mag = diff2[S+1] ? -diff2 : diff2;
  assign mul_out  = PROD_W'(diff_mag) * PROD_W'(axis_scale[axis]);

  assign rnd_sum = {1'b0, prod} + RND_HALF;
  assign rnd_val = rnd_sum[PROD_W:OUT_SHIFT];
  assign r_ext   = CMP_W'(rnd_val);

  always_comb begin
    if (prod_neg) begin
      cal_new = (r_ext > NEG_LIM) ? mmc_pkg::CAL_MIN : CAL_W'(-r_ext);
    end else begin
      cal_new = (r_ext > POS_LIM) ? mmc_pkg::CAL_MAX : CAL_W'(r_ext);
    end
  end

  assign out_free     = !out_valid || result.ready;
  assign sample.ready = (state == ST_IDLE);

  assign result.valid       = out_valid;
  assign result.cal_x       = out_cal[0];
  assign result.cal_y       = out_cal[1];
  assign result.cal_z       = out_cal[2];
  assign result.report_kind = out_report;
  assign result.scale_error = out_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      axis      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < mmc_pkg::AXES; i++) begin
        track_min[i]  <= TRACK_HI;
        track_max[i]  <= TRACK_LO;
        offset_sum[i] <= '0;
        axis_scale[i] <= SCALE_ONE;
      end
    end else begin
      // the emit step reloads the output itself
      if (out_valid && result.ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            raw_q[0] <= sample.raw_x;
            raw_q[1] <= sample.raw_y;
            raw_q[2] <= sample.raw_z;
            axis     <= '0;
            case (sample.kind)
              mmc_pkg::KIND_START: begin
                for (int i = 0; i < mmc_pkg::AXES; i++) begin
                  track_min[i] <= TRACK_HI;
                  track_max[i] <= TRACK_LO;
                end
              end
              mmc_pkg::KIND_CAL: begin
                state <= ST_TRACK;
              end
              mmc_pkg::KIND_FINISH: begin
                span_sum <= '0;
                span_err <= 1'b0;
                report   <= mmc_pkg::REPORT_FINISH;
                state    <= ST_SPAN;
              end
              default: begin
                report <= mmc_pkg::REPORT_MEASURE;
                state  <= ST_MUL;
              end
            endcase
          end
        end
        ST_TRACK: begin
          if (cur_raw < cur_min) begin
            track_min[axis] <= cur_raw;
          end
          if (cur_raw > cur_max) begin
            track_max[axis] <= cur_raw;
          end
          axis <= axis + 2'd1;
          if (axis == 2'd2) begin
            state <= ST_IDLE;
          end
        end
        ST_SPAN: begin
          offset_sum[axis] <= off_new;
          span[axis]       <= span_new;
          span_sum         <= span_sum + {{2{span_new[S-1]}}, span_new};
          span_err         <= span_err || (span_new == '0);
          if (axis == 2'd2) begin
            axis  <= '0;
            state <= (span_err || (span_new == '0)) ? ST_EMIT : ST_DIV_START;
          end else begin
            axis <= axis + 2'd1;
          end
        end
        ST_DIV_START: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            axis_scale[axis] <= scale_new;
            if (axis == 2'd2) begin
              state <= ST_EMIT;
            end else begin
              axis  <= axis + 2'd1;
              state <= ST_DIV_START;
            end
          end
        end
        ST_MUL: begin
          prod     <= mul_out;
          prod_neg <= diff2[S+1];
          state    <= ST_RND;
        end
        ST_RND: begin
          cal_acc[axis] <= cal_new;
          if (axis == 2'd2) begin
            state <= ST_EMIT;
          end else begin
            axis  <= axis + 2'd1;
            state <= ST_MUL;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            for (int i = 0; i < mmc_pkg::AXES; i++) begin
              out_cal[i] <= (report == mmc_pkg::REPORT_FINISH) ? '0 : cal_acc[i];
            end
            out_report <= report;
            out_error  <= (report == mmc_pkg::REPORT_FINISH) ? span_err : 1'b0;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a result beat only ever comes out of the emit step
  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EMIT)
    else $error("result beat raised outside emit");

  // the divider only finishes while the sequencer waits on it
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV_WAIT)
    else $error("divider finished out of sequence");

  // measurement beats never carry the scale error flag
  a_measure_no_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_report == mmc_pkg::REPORT_MEASURE |-> !out_error)
    else $error("scale error on a measurement beat");

  // finish reports carry zero readings
  a_finish_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_report == mmc_pkg::REPORT_FINISH |->
      out_cal[0] == '0 && out_cal[1] == '0 && out_cal[2] == '0)
    else $error("finish report with non-zero readings");

endmodule
